// ===== rtl/wpm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Wildcard pattern matcher package
// Sizes, character constants, command codes and the control/status
// bundles shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package wpm_pkg;

	// Largest pattern the store holds, in bytes.
	localparam int MAX_PATTERN = 64;
	localparam int LEN_W = $clog2(MAX_PATTERN + 1);
	localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	localparam logic [7:0] STAR_CHAR  = 8'h2A;
	localparam logic [7:0] QMARK_CHAR = 8'h3F;

	// Codes carried by the kind field of an input word.
	localparam logic [1:0] KIND_CLEAR   = 2'd0;
	localparam logic [1:0] KIND_APPEND  = 2'd1;
	localparam logic [1:0] KIND_RESTART = 2'd2;
	localparam logic [1:0] KIND_TEXT    = 2'd3;

	typedef logic [MAX_PATTERN-1:0] col_t;
	typedef logic [LEN_W-1:0]       len_t;

	// Strobes from the controller to the datapath.
	typedef struct packed {
		logic do_clear;
		logic do_append;
		logic do_restart;
		logic do_text;
		logic overflow;
		logic out_load_new;
		logic out_load_skid;
		logic skid_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic store_full;
	} status_t;

endpackage
`default_nettype wire

// ===== rtl/wildcard_pattern_matcher.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Wildcard pattern matcher
// Streaming whole-string match of text against a pattern with '?' and '*'.
// ----------------------------------------------------------------------------
// The block takes one input word per clock cycle while cmd_stall is low
// and returns exactly one result word per input word, in order.
// A word either clears the pattern, appends a pattern byte, restarts the
// text, or feeds one text byte. The result tells whether the text received
// since the last restart matches the whole loaded pattern, and whether an
// append was dropped because the pattern store already holds MAX_PATTERN
// bytes. Results pass through a two-entry buffer, so input words keep being
// taken while one finished result waits downstream; input stalls only when
// both entries are occupied. The cycle time is set by the text byte update,
// where all pattern columns are evaluated at once and runs of '*' columns
// are resolved by a carry chain as wide as the pattern store.
module wildcard_pattern_matcher (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cmd_valid,
	output logic            cmd_stall,
	input  wire logic [1:0] kind,
	input  wire logic [7:0] character,
	output logic            result_valid,
	input  wire logic       result_stall,
	output logic            full_match,
	output logic            pattern_overflow
);
	import wpm_pkg::*;

	cmd_t    cmd;
	status_t status;

	// Handshakes, command decode and result buffer occupancy.
	wpm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.kind         (kind),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	// Pattern store, match row and result registers.
	wpm_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.character        (character),
		.cmd              (cmd),
		.status           (status),
		.full_match       (full_match),
		.pattern_overflow (pattern_overflow)
	);

	// Every accepted word leaves a result waiting in the buffer.
	a_result_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> result_valid)
		else $error("accepted word produced no result");

	// Input only stalls when a result is held at the output.
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> result_valid)
		else $error("input stalled with empty result buffer");

	// A dropped append happens only with a full store, and never writes it.
	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.overflow || cmd.do_append) |-> (cmd.overflow == status.store_full))
		else $error("append overflow decision disagrees with store fill");

	// At most one operation acts on the pattern state per cycle.
	a_single_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.do_clear, cmd.do_append, cmd.do_restart, cmd.do_text,
			cmd.overflow}))
		else $error("more than one operation issued in a cycle");

endmodule
`default_nettype wire

// ===== rtl/wpm_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Wildcard pattern matcher controller
// Input handshake, command decode and the two-entry result buffer state.
// ----------------------------------------------------------------------------
module wpm_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cmd_valid,
	output logic                 cmd_stall,
	input  wire logic [1:0]      kind,
	output logic                 result_valid,
	input  wire logic            result_stall,
	input  wire wpm_pkg::status_t status,
	output wpm_pkg::cmd_t        cmd
);
	import wpm_pkg::*;

	// Occupancy of the result buffer (output register plus skid entry).
	localparam logic [1:0] ST_EMPTY = 2'd0;
	localparam logic [1:0] ST_ONE   = 2'd1;
	localparam logic [1:0] ST_TWO   = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_next;
	logic       accept;
	logic       take;

	assign cmd_stall    = (state_q == ST_TWO);
	assign result_valid = (state_q != ST_EMPTY);
	assign accept       = cmd_valid & ~cmd_stall;
	assign take         = result_valid & ~result_stall;

	always_comb begin
		cmd            = '0;
		state_next     = state_q;
		cmd.do_clear   = accept & (kind == KIND_CLEAR);
		cmd.do_append  = accept & (kind == KIND_APPEND) & ~status.store_full;
		cmd.overflow   = accept & (kind == KIND_APPEND) & status.store_full;
		cmd.do_restart = accept & (kind == KIND_RESTART);
		cmd.do_text    = accept & (kind == KIND_TEXT);
		unique case (state_q)
			ST_EMPTY: begin
				if (accept) begin
					cmd.out_load_new = 1'b1;
					state_next       = ST_ONE;
				end
			end
			ST_ONE: begin
				if (take && accept) begin
					cmd.out_load_new = 1'b1;
				end else if (take) begin
					state_next = ST_EMPTY;
				end else if (accept) begin
					cmd.skid_load = 1'b1;
					state_next    = ST_TWO;
				end
			end
			ST_TWO: begin
				if (take) begin
					cmd.out_load_skid = 1'b1;
					state_next        = ST_ONE;
				end
			end
			default: begin
				state_next = ST_EMPTY;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EMPTY;
		end else begin
			state_q <= state_next;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/wpm_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Wildcard pattern matcher datapath
// Pattern store, match row update and the result buffer registers.
// ----------------------------------------------------------------------------
module wpm_datapath (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [7:0]      character,
	input  wire wpm_pkg::cmd_t   cmd,
	output wpm_pkg::status_t     status,
	output logic                 full_match,
	output logic                 pattern_overflow
);
	import wpm_pkg::*;

	logic [7:0] store_q [MAX_PATTERN];
	len_t       length_q;
	col_t       col_valid_q;
	col_t       last_col_q;
	col_t       lead_row_q;
	logic       all_star_q;
	col_t       row_q;
	logic       text_empty_q;

	logic       skid_full_q;
	logic       skid_ovf_q;
	logic       out_full_q;
	logic       out_ovf_q;

	col_t       new_bit;
	logic       char_star;
	col_t       lead_append;
	col_t       star_col;
	col_t       g_col;
	col_t       gp_col;
	col_t       left_old;
	col_t       sum;
	col_t       carry_in;
	col_t       text_row;

	len_t       length_next;
	col_t       col_valid_next;
	col_t       last_col_next;
	col_t       lead_row_next;
	logic       all_star_next;
	col_t       row_next;
	logic       text_empty_next;
	logic       result_full;

	assign status.store_full = col_valid_q[MAX_PATTERN-1];

	assign new_bit     = col_t'(1) << length_q[IDX_W-1:0];
	assign char_star   = (character == STAR_CHAR);
	assign lead_append = lead_row_q | ((all_star_q & char_star) ? new_bit : '0);
	assign left_old    = col_t'({row_q, text_empty_q});

	// Each column can generate a match bit; a star column also passes the
	// left neighbor's new bit along; the adder carry resolves that chain.
	always_comb begin
		for (int j = 0; j < MAX_PATTERN; j++) begin
			star_col[j] = col_valid_q[j] & (store_q[j] == STAR_CHAR);
			g_col[j]    = (star_col[j] & row_q[j]) |
				(col_valid_q[j] & ~star_col[j] & left_old[j] &
				((store_q[j] == QMARK_CHAR) | (store_q[j] == character)));
			gp_col[j]   = g_col[j] | star_col[j];
		end
	end

	// The carry out of the last column is never needed.
	assign sum      = g_col + gp_col;
	assign carry_in = sum ^ g_col ^ gp_col;
	assign text_row = g_col | (star_col & carry_in);

	always_comb begin
		length_next     = length_q;
		col_valid_next  = col_valid_q;
		last_col_next   = last_col_q;
		lead_row_next   = lead_row_q;
		all_star_next   = all_star_q;
		row_next        = row_q;
		text_empty_next = text_empty_q;
		priority if (cmd.do_clear) begin
			length_next     = '0;
			col_valid_next  = '0;
			last_col_next   = '0;
			lead_row_next   = '0;
			all_star_next   = 1'b1;
			row_next        = '0;
			text_empty_next = 1'b1;
		end else if (cmd.do_append) begin
			length_next     = length_q + len_t'(1);
			col_valid_next  = col_valid_q | new_bit;
			last_col_next   = new_bit;
			lead_row_next   = lead_append;
			all_star_next   = all_star_q & char_star;
			row_next        = lead_append;
			text_empty_next = 1'b1;
		end else if (cmd.do_restart) begin
			row_next        = lead_row_q;
			text_empty_next = 1'b1;
		end else if (cmd.do_text) begin
			row_next        = text_row;
			text_empty_next = 1'b0;
		end
	end

	// With an empty pattern the whole-pattern match is the empty-text flag.
	assign result_full = (|(row_next & last_col_next)) |
		(text_empty_next & ~(|col_valid_next));

	always_ff @(posedge clk) begin
		if (cmd.do_append) begin
			store_q[length_q[IDX_W-1:0]] <= character;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q     <= '0;
			col_valid_q  <= '0;
			last_col_q   <= '0;
			lead_row_q   <= '0;
			all_star_q   <= 1'b1;
			row_q        <= '0;
			text_empty_q <= 1'b1;
		end else begin
			length_q     <= length_next;
			col_valid_q  <= col_valid_next;
			last_col_q   <= last_col_next;
			lead_row_q   <= lead_row_next;
			all_star_q   <= all_star_next;
			row_q        <= row_next;
			text_empty_q <= text_empty_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.skid_load) begin
			skid_full_q <= result_full;
			skid_ovf_q  <= cmd.overflow;
		end
		if (cmd.out_load_new) begin
			out_full_q <= result_full;
			out_ovf_q  <= cmd.overflow;
		end else if (cmd.out_load_skid) begin
			out_full_q <= skid_full_q;
			out_ovf_q  <= skid_ovf_q;
		end
	end

	assign full_match       = out_full_q;
	assign pattern_overflow = out_ovf_q;

endmodule
`default_nettype wire
